>>> sv/nqb_pkg.sv
// ----------------------------------------------------------------------------
// nqb_pkg
// Shared constants and codes for the N-queens backtracking stepper.
// ----------------------------------------------------------------------------
package nqb_pkg;

   localparam int MAX_SIZE = 16;
   localparam int ROW_W    = $clog2(MAX_SIZE);
   localparam int CNT_W    = $clog2(MAX_SIZE + 1);

   // fixed widths of the external fields
   localparam int SIZE_W   = 5;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 2;
   localparam int ACTION_W = 2;
   localparam int STEP_W   = 32;

   localparam int unsigned BOARD_SIZE_RESET = 8;

   // search status codes
   localparam logic [STATUS_W-1:0] STATUS_RUNNING     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FINISHED    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_SOLUTION = 2'd2;

   // action codes
   localparam logic [ACTION_W-1:0] ACTION_NONE    = 2'd0;
   localparam logic [ACTION_W-1:0] ACTION_PLACED  = 2'd1;
   localparam logic [ACTION_W-1:0] ACTION_REMOVED = 2'd2;

   typedef logic [ROW_W-1:0] row_type;

endpackage

>>> sv/nqb_if.sv
// ----------------------------------------------------------------------------
// nqb_if
// Request and response channel interfaces of the N-queens stepper.
// ----------------------------------------------------------------------------
interface nqb_req_if;
   logic valid;
   logic ready;
   logic advance;

   modport source (output valid, output advance, input ready);
   modport sink   (input valid, input advance, output ready);
endinterface

interface nqb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [nqb_pkg::STATUS_W-1:0]  search_status;
   logic [nqb_pkg::POS_W-1:0]     column;
   logic [nqb_pkg::POS_W-1:0]     row;
   logic [nqb_pkg::ACTION_W-1:0]  action;
   logic [nqb_pkg::STEP_W-1:0]    step_count;

   modport source (output valid, output search_status, output column, output row,
                   output action, output step_count, input ready);
   modport sink   (input valid, input search_status, input column, input row,
                   input action, input step_count, output ready);
endinterface

>>> sv/n_queens_backtrack_stepper.sv
// ----------------------------------------------------------------------------
// n_queens_backtrack_stepper
// Sequencing: a request without a step goes straight to the emit state; one
//   with a step first scans one candidate row per cycle through the shared
//   attack checker until a free row is found or the column runs out.
// Requests are taken one at a time, only while idle; the next is taken once
//   the response is in the output register, held up while rsp.ready is low.
// Reset (synchronous, active high): board size 8, board empty, status running.
// ----------------------------------------------------------------------------
module n_queens_backtrack_stepper (
   input  logic                          clock,
   input  logic                          reset,
   nqb_req_if.sink                       req,
   nqb_rsp_if.source                     rsp,
   input  logic                          csr_write_enable,
   input  logic [nqb_pkg::SIZE_W-1:0]    csr_write_data
);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]                      state_ff, state_in;
   logic [nqb_pkg::SIZE_W-1:0]      board_size_ff, board_size_in;
   logic [nqb_pkg::CNT_W-1:0]       cur_col_ff, cur_col_in;
   logic [nqb_pkg::CNT_W-1:0]       resume_row_ff, resume_row_in;
   logic [nqb_pkg::CNT_W-1:0]       scan_row_ff, scan_row_in;
   logic [nqb_pkg::STATUS_W-1:0]    run_status_ff, run_status_in;
   logic [nqb_pkg::STEP_W-1:0]      steps_ff, steps_in;

   // result of the step in flight, held until the output register is free
   logic [nqb_pkg::POS_W-1:0]       pend_col_ff, pend_col_in;
   logic [nqb_pkg::POS_W-1:0]       pend_row_ff, pend_row_in;
   logic [nqb_pkg::ACTION_W-1:0]    pend_act_ff, pend_act_in;

   // output register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [nqb_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [nqb_pkg::POS_W-1:0]       rsp_col_ff, rsp_col_in;
   logic [nqb_pkg::POS_W-1:0]       rsp_row_ff, rsp_row_in;
   logic [nqb_pkg::ACTION_W-1:0]    rsp_act_ff, rsp_act_in;
   logic [nqb_pkg::STEP_W-1:0]      rsp_steps_ff, rsp_steps_in;

   // queen row per column; column c holds a queen exactly when c < cur_col_ff
   nqb_pkg::row_type                queen_rows_ff [nqb_pkg::MAX_SIZE];
   logic                            place_queen;

   logic [nqb_pkg::CNT_W-1:0]       size_n;
   logic [nqb_pkg::CNT_W-1:0]       prev_col;
   logic                            attacked;
   logic                            req_xfer;
   logic                            out_free;

   // board size clamp: 0 acts as 1, anything above the maximum as the maximum
   always_comb begin
      if (board_size_ff == '0) begin
         size_n = nqb_pkg::CNT_W'(1);
      end else if (nqb_pkg::CNT_W'(board_size_ff) > nqb_pkg::CNT_W'(nqb_pkg::MAX_SIZE)) begin
         size_n = nqb_pkg::CNT_W'(nqb_pkg::MAX_SIZE);
      end else begin
         size_n = nqb_pkg::CNT_W'(board_size_ff);
      end
   end

   nqb_attack_unit u_attack (
      .queen_rows   (queen_rows_ff),
      .placed_count (cur_col_ff),
      .cand_row     (scan_row_ff[nqb_pkg::ROW_W-1:0]),
      .attacked     (attacked)
   );

   assign req.ready = (state_ff == ST_IDLE);
   assign req_xfer  = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign prev_col  = cur_col_ff - nqb_pkg::CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      board_size_in = board_size_ff;
      cur_col_in    = cur_col_ff;
      resume_row_in = resume_row_ff;
      scan_row_in   = scan_row_ff;
      run_status_in = run_status_ff;
      steps_in      = steps_ff;
      pend_col_in   = pend_col_ff;
      pend_row_in   = pend_row_ff;
      pend_act_in   = pend_act_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_act_in    = rsp_act_ff;
      rsp_steps_in  = rsp_steps_ff;
      place_queen   = 1'b0;

      // output register drains on its own transfer
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               pend_col_in = '0;
               pend_row_in = '0;
               pend_act_in = nqb_pkg::ACTION_NONE;
               if (req.advance && (run_status_ff == nqb_pkg::STATUS_RUNNING)) begin
                  scan_row_in = resume_row_ff;
                  state_in    = ST_SCAN;
               end else begin
                  state_in    = ST_EMIT;
               end
            end
         end
         ST_SCAN: begin
            // one candidate row per cycle
            if (scan_row_ff >= size_n) begin
               // column exhausted: backtrack or give up
               steps_in = steps_ff + nqb_pkg::STEP_W'(1);
               state_in = ST_EMIT;
               if (cur_col_ff == '0) begin
                  run_status_in = nqb_pkg::STATUS_NO_SOLUTION;
               end else begin
                  cur_col_in    = prev_col;
                  resume_row_in = nqb_pkg::CNT_W'(queen_rows_ff[prev_col[nqb_pkg::ROW_W-1:0]])
                                  + nqb_pkg::CNT_W'(1);
                  pend_col_in   = nqb_pkg::POS_W'(prev_col);
                  pend_row_in   = nqb_pkg::POS_W'(queen_rows_ff[prev_col[nqb_pkg::ROW_W-1:0]]);
                  pend_act_in   = nqb_pkg::ACTION_REMOVED;
               end
            end else if (!attacked) begin
               place_queen   = 1'b1;
               cur_col_in    = cur_col_ff + nqb_pkg::CNT_W'(1);
               resume_row_in = '0;
               steps_in      = steps_ff + nqb_pkg::STEP_W'(1);
               pend_col_in   = nqb_pkg::POS_W'(cur_col_ff);
               pend_row_in   = nqb_pkg::POS_W'(scan_row_ff);
               pend_act_in   = nqb_pkg::ACTION_PLACED;
               state_in      = ST_EMIT;
               if ((cur_col_ff + nqb_pkg::CNT_W'(1)) >= size_n) begin
                  run_status_in = nqb_pkg::STATUS_FINISHED;
               end
            end else begin
               scan_row_in = scan_row_ff + nqb_pkg::CNT_W'(1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = run_status_ff;
               rsp_col_in    = pend_col_ff;
               rsp_row_in    = pend_row_ff;
               rsp_act_in    = pend_act_ff;
               rsp_steps_in  = steps_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register write restarts search; user issues it only while idle (unchecked)
      if (csr_write_enable) begin
         board_size_in = csr_write_data;
         cur_col_in    = '0;
         resume_row_in = '0;
         run_status_in = nqb_pkg::STATUS_RUNNING;
         steps_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         board_size_ff <= nqb_pkg::SIZE_W'(nqb_pkg::BOARD_SIZE_RESET);
         cur_col_ff    <= '0;
         resume_row_ff <= '0;
         run_status_ff <= nqb_pkg::STATUS_RUNNING;
         steps_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         board_size_ff <= board_size_in;
         cur_col_ff    <= cur_col_in;
         resume_row_ff <= resume_row_in;
         run_status_ff <= run_status_in;
         steps_ff      <= steps_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      scan_row_ff   <= scan_row_in;
      pend_col_ff   <= pend_col_in;
      pend_row_ff   <= pend_row_in;
      pend_act_ff   <= pend_act_in;
      rsp_status_ff <= rsp_status_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_act_ff    <= rsp_act_in;
      rsp_steps_ff  <= rsp_steps_in;
      if (place_queen) begin
         queen_rows_ff[cur_col_ff[nqb_pkg::ROW_W-1:0]] <= scan_row_ff[nqb_pkg::ROW_W-1:0];
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.search_status = rsp_status_ff;
   assign rsp.column        = rsp_col_ff;
   assign rsp.row           = rsp_row_ff;
   assign rsp.action        = rsp_act_ff;
   assign rsp.step_count    = rsp_steps_ff;

endmodule

>>> sv/nqb_attack_unit.sv
// ----------------------------------------------------------------------------
// nqb_attack_unit
// Checks one candidate row of the current column against all placed queens.
// ----------------------------------------------------------------------------
module nqb_attack_unit (
   input  nqb_pkg::row_type               queen_rows [nqb_pkg::MAX_SIZE],
   input  logic [nqb_pkg::CNT_W-1:0]      placed_count,
   input  nqb_pkg::row_type               cand_row,
   output logic                           attacked
);

   logic [nqb_pkg::MAX_SIZE-1:0] hit;

   for (genvar c = 0; c < nqb_pkg::MAX_SIZE; c++) begin : g_lane
      logic [nqb_pkg::CNT_W-1:0] col_dist;
      logic [nqb_pkg::ROW_W-1:0] row_dist;

      always_comb begin
         // only columns below placed_count hold queens, so the distance is positive
         col_dist = placed_count - nqb_pkg::CNT_W'(c);
         if (queen_rows[c] > cand_row) begin
            row_dist = queen_rows[c] - cand_row;
         end else begin
            row_dist = cand_row - queen_rows[c];
         end
         hit[c] = (nqb_pkg::CNT_W'(c) < placed_count) &&
                  ((queen_rows[c] == cand_row) ||
                   (col_dist == nqb_pkg::CNT_W'(row_dist)));
      end
   end

   assign attacked = |hit;

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives search steps into the N-queens stepper over the request channel and
// checks every response against an in-bench model of the backtracking search.
// Board sizes change between phases, only while the block is idle. The sender
// works in random bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int RANDOM_BUDGET = 1400;   // random step transfers to queue
   localparam int DRAIN_CYCLES  = 24;     // longer than the slowest step

   // one expected response
   typedef struct {
      logic [nqb_pkg::STATUS_W-1:0] search_status;
      logic [nqb_pkg::POS_W-1:0]    column;
      logic [nqb_pkg::POS_W-1:0]    row;
      logic [nqb_pkg::ACTION_W-1:0] action;
      logic [nqb_pkg::STEP_W-1:0]   step_count;
   } step_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                       csr_write_enable = 1'b0;
   logic [nqb_pkg::SIZE_W-1:0] csr_write_data   = '0;

   nqb_req_if req_bus ();
   nqb_rsp_if rsp_bus ();

   n_queens_backtrack_stepper DUT (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Search model: board setting, placed queens and search position
   // ------------------------------------------------------------------------
   logic [nqb_pkg::SIZE_W-1:0]   board_setting = nqb_pkg::SIZE_W'(nqb_pkg::BOARD_SIZE_RESET);
   nqb_pkg::row_type             queen_row [nqb_pkg::MAX_SIZE];
   bit                           queen_set [nqb_pkg::MAX_SIZE];
   int                           search_col  = 0;
   int                           resume_from = 0;
   logic [nqb_pkg::STATUS_W-1:0] search_state = nqb_pkg::STATUS_RUNNING;
   logic [nqb_pkg::STEP_W-1:0]   steps_done   = '0;

   step_report_type pending_reports [$];   // expected responses, oldest first
   bit              step_queue [$];        // advance bits waiting to be sent
   int              untransferred = 0;     // queued but not yet transferred
   int              fail_count    = 0;
   int              cycle_count   = 0;

   // Clear the board and restart the search, as a size write does.
   function automatic void restart_search(logic [nqb_pkg::SIZE_W-1:0] value);
      board_setting = value;
      foreach (queen_set[c]) begin
         queen_set[c] = 1'b0;
         queen_row[c] = '0;
      end
      search_col   = 0;
      resume_from  = 0;
      search_state = nqb_pkg::STATUS_RUNNING;
      steps_done   = '0;
   endfunction

   // One transfer of the request channel: take a step if asked and running,
   // then report the state after it.
   function automatic step_report_type take_search_step(bit advance);
      step_report_type res;
      int  n, col, r, pc, pr, q;
      bit  found, hit;
      res.column = '0;
      res.row    = '0;
      res.action = nqb_pkg::ACTION_NONE;
      if (advance && search_state == nqb_pkg::STATUS_RUNNING) begin
         // size 0 behaves as 1, oversize as the full board
         if (board_setting == 0)
            n = 1;
         else if (board_setting > nqb_pkg::MAX_SIZE)
            n = nqb_pkg::MAX_SIZE;
         else
            n = int'(board_setting);
         col   = search_col;
         found = 1'b0;
         r     = resume_from;
         // lowest free row at or above the resume row
         while (!found && col < n && r < n) begin
            hit = 1'b0;
            for (int c = 0; c < nqb_pkg::MAX_SIZE; c++) begin
               if (queen_set[c] && c != col) begin
                  q = int'(queen_row[c]);
                  if (q == r || (c - col) == (q - r) || (c - col) == (r - q))
                     hit = 1'b1;
               end
            end
            if (hit)
               r++;
            else
               found = 1'b1;
         end
         if (found) begin
            queen_row[col] = nqb_pkg::row_type'(r);
            queen_set[col] = 1'b1;
            res.column     = nqb_pkg::POS_W'(col);
            res.row        = nqb_pkg::POS_W'(r);
            res.action     = nqb_pkg::ACTION_PLACED;
            search_col     = col + 1;
            resume_from    = 0;
            if (search_col >= n)
               search_state = nqb_pkg::STATUS_FINISHED;
         end else if (col == 0) begin
            // nothing left to try in the first column
            search_state = nqb_pkg::STATUS_NO_SOLUTION;
         end else begin
            // lift the previous queen and retry one row past it
            pc             = col - 1;
            pr             = int'(queen_row[pc]);
            search_col     = pc;
            resume_from    = pr + 1;
            queen_set[pc]  = 1'b0;
            queen_row[pc]  = '0;
            res.column     = nqb_pkg::POS_W'(pc);
            res.row        = nqb_pkg::POS_W'(pr);
            res.action     = nqb_pkg::ACTION_REMOVED;
         end
         steps_done = steps_done + nqb_pkg::STEP_W'(1);
      end
      res.search_status = search_state;
      res.step_count    = steps_done;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: bursts of random length with random gaps in between.
   // Prediction happens at the edge where the transfer takes place.
   // ------------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.advance <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            pending_reports.push_back(take_search_step(req_bus.advance));
            untransferred--;
         end
         // load the next item once the current one is gone
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left != 0 || step_queue.size() == 0) begin
               if (gap_left != 0)
                  gap_left--;
               req_bus.valid   <= 1'b0;
               req_bus.advance <= 1'($urandom_range(0, 1));   // noise while idle
            end else begin
               req_bus.valid   <= 1'b1;
               req_bus.advance <= step_queue.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  // a quarter of bursts run straight into the next one
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor: checks each transfer against the oldest expectation.
   // Ready follows a stall mode that is redrawn after each random run.
   // ------------------------------------------------------------------------
   int              stall_mode = 0;
   int              stall_run  = 0;
   step_report_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_run = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_reports.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: response with none pending: status %0d col %0d",
                           $realtime, rsp_bus.search_status, rsp_bus.column,
                           " row %0d act %0d steps %0d",
                           rsp_bus.row, rsp_bus.action, rsp_bus.step_count);
            end else begin
               want = pending_reports.pop_front();
               if ({rsp_bus.search_status, rsp_bus.column, rsp_bus.row, rsp_bus.action,
                    rsp_bus.step_count} !==
                   {want.search_status, want.column, want.row, want.action,
                    want.step_count}) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: mismatch: want status %0d col %0d row %0d act %0d",
                              $realtime, want.search_status, want.column, want.row,
                              want.action,
                              " steps %0d, got status %0d col %0d row %0d",
                              want.step_count, rsp_bus.search_status,
                              rsp_bus.column, rsp_bus.row,
                              " act %0d steps %0d",
                              rsp_bus.action, rsp_bus.step_count);
               end
            end
         end
         if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_run  = $urandom_range(16, 96);
         end else begin
            stall_run--;
         end
         case (stall_mode)
            0: begin
               rsp_bus.ready <= 1'b1;
            end
            1: begin
               rsp_bus.ready <= 1'($urandom_range(0, 1));
            end
            default: begin
               rsp_bus.ready <= ($urandom_range(0, 7) == 0);
            end
         endcase
      end
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[n_queens_backtrack_stepper] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   // Queue steps; idle_pct percent of them are report-only.
   task automatic queue_steps(input int count, input int idle_pct);
      for (int i = 0; i < count; i++)
         step_queue.push_back($urandom_range(1, 100) > idle_pct);
      untransferred += count;
   endtask

   // Hold off until every queued step is transferred and answered.
   task automatic wait_for_drain();
      do
         @(posedge clock);
      while (untransferred != 0 || pending_reports.size() != 0);
   endtask

   // Size write, only with the block idle; the model restarts with it.
   task automatic load_board_size(input logic [nqb_pkg::SIZE_W-1:0] value);
      wait_for_drain();
      repeat (2) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      restart_search(value);
   endtask

   int                         random_total;
   int                         phase_len;
   int                         pick;
   logic [nqb_pkg::SIZE_W-1:0] next_size;

   initial begin
      restart_search(nqb_pkg::SIZE_W'(nqb_pkg::BOARD_SIZE_RESET));
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset size of 8: report-only first, then the opening steps of the search
      queue_steps(1, 100);
      queue_steps(7, 0);

      // size 0 acts as 1: one placement finishes, the next step does nothing
      load_board_size('0);
      queue_steps(2, 0);

      // 3x3 has no solution: walks back through column 0 and stops there
      load_board_size(nqb_pkg::SIZE_W'(3));
      queue_steps(12, 0);
      queue_steps(1, 100);

      // random phases; the first few cover the size extremes
      random_total = 0;
      pick = 0;
      while (random_total < RANDOM_BUDGET) begin
         case (pick)
            0: next_size = nqb_pkg::SIZE_W'(31);
            1: next_size = nqb_pkg::SIZE_W'(nqb_pkg::MAX_SIZE);
            2: next_size = nqb_pkg::SIZE_W'(1);
            3: next_size = nqb_pkg::SIZE_W'(2);
            default: begin
               case ($urandom_range(0, 9))
                  0:       next_size = '0;
                  1:       next_size = nqb_pkg::SIZE_W'($urandom_range(17, 31));
                  2:       next_size = nqb_pkg::SIZE_W'($urandom_range(9, nqb_pkg::MAX_SIZE));
                  default: next_size = nqb_pkg::SIZE_W'($urandom_range(1, 8));
               endcase
            end
         endcase
         pick++;
         load_board_size(next_size);
         phase_len = (next_size >= 1 && next_size <= 8) ? $urandom_range(20, 250)
                                                        : $urandom_range(20, 120);
         // now and then pause mid-search until every response is back
         if ($urandom_range(0, 3) == 0) begin
            queue_steps(phase_len / 2, 8);
            wait_for_drain();
            queue_steps(phase_len - phase_len / 2, 8);
         end else begin
            queue_steps(phase_len, 8);
         end
         random_total += phase_len;
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("[n_queens_backtrack_stepper] OK");
      else
         $display("[n_queens_backtrack_stepper] ERROR");
      $finish;
   end

endmodule

>>> filelist.f
sv/nqb_pkg.sv
sv/nqb_if.sv
sv/nqb_attack_unit.sv
sv/n_queens_backtrack_stepper.sv
test/testbench.sv
